/* rtl/core/rtt_window_statistics_core_assert.svh */
// assertion macros used by the checker file rws_checker.sv
`ifndef RTT_WINDOW_STATISTICS_CORE_ASSERT_SVH
`define RTT_WINDOW_STATISTICS_CORE_ASSERT_SVH

// clocked assertion, muted while reset is asserted
`define RWS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
	else $error("rtt window statistics assertion failed");

// clocked assertion that also holds through reset
`define RWS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("rtt window statistics assertion failed");

`endif

/* rtl/core/rws_pkg.sv */
`timescale 1ns / 1ps
package rws_pkg;
	localparam int SAMPLE_W = 28;
	localparam int HELD_W = 6;
	localparam int VAR_W = 56;
	localparam int ROOT_W = 28;
	localparam logic [SAMPLE_W-1:0] MIN_RESET = 28'd255999744;
endpackage

/* rtl/core/rtt_window_statistics_core.sv */
`timescale 1ns / 1ps
// NW = clog2(WINDOW+1), SW = 28+NW, PW = 56+2*NW; once the window is full the evicted sample
// is also squared and taken out of the sums; no new sample is taken until the last one's result
// is registered, so a waiting result also holds off input;
// the shift-add multiplier, the restoring divider and the square root run one bit per cycle
// reset: min 999999 ms, max, count, sum and slot cleared; ring contents are undefined
// until written and only values from written slots are ever used
module rtt_window_statistics_core
	import rws_pkg::*;
#(
	parameter int WINDOW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] rtt_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] mean_rtt,
	output logic [SAMPLE_W-1:0] min_rtt,
	output logic [SAMPLE_W-1:0] max_rtt,
	output logic [SAMPLE_W-1:0] jitter_rtt,
	output logic [HELD_W-1:0]   samples_held
);
	localparam int NW = $clog2(WINDOW + 1);
	localparam int SLW = $clog2(WINDOW);
	localparam int SW = SAMPLE_W + NW;
	localparam int S2W = 2 * SAMPLE_W + NW;
	localparam int PW = 2 * SAMPLE_W + 2 * NW;
	localparam int NNW = 2 * NW;
	localparam int MCW = $clog2(SW + 1);
	localparam int DCW = $clog2(PW + 1);
	localparam int RCW = $clog2(ROOT_W + 1);
	localparam int RMW = ROOT_W + 4;

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_SQRT, ST_DONE} state_t;
	typedef enum logic [2:0] {OP_SQ_NEW, OP_SQ_OLD, OP_N_S2, OP_S1_SQ, OP_NN} mul_op_t;
	typedef enum logic {DV_VAR, DV_MEAN} div_op_t;

	logic [SAMPLE_W-1:0] ring_mem [WINDOW];
	logic [SAMPLE_W-1:0] ring_rd_q;

	state_t  state_q;
	mul_op_t mul_op_q;
	div_op_t div_op_q;

	logic [SAMPLE_W-1:0] s_q, old_q, lowest_q, highest_q, mean_q;
	logic [SLW-1:0]      slot_q;
	logic [NW-1:0]       fill_q;
	logic [SW-1:0]       sum_q;
	logic [S2W-1:0]      s2_q;
	logic                was_full_q;
	logic [PW-1:0]       ns2_q, num_q;

	logic [PW-1:0]  mul_a_q, mul_p_q, mul_next;
	logic [SW-1:0]  mul_b_q;
	logic [MCW-1:0] mul_cnt_q;

	logic [PW-1:0]  div_dd_q, div_q_q, div_qn;
	logic [NNW-1:0] div_d_q, div_rem_q, div_rem_n;
	logic [NNW:0]   div_t;
	logic [DCW-1:0] div_cnt_q;
	logic           div_ge;

	logic [VAR_W-1:0]  sq_v_q;
	logic [RMW-1:0]    sq_rem_q, sq_t, sq_trial, sq_rem_n;
	logic [ROOT_W-1:0] sq_root_q, sq_root_n;
	logic [RCW-1:0]    sq_cnt_q;
	logic              sq_ge;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] mean_o_q, min_o_q, max_o_q, jit_o_q;
	logic [NW-1:0]       held_o_q;

	logic full;

	assign full = (fill_q == NW'(WINDOW));
	assign in_ready = (state_q == ST_IDLE);

	assign mul_next = mul_p_q + (mul_b_q[0] ? mul_a_q : '0);

	assign div_t = {div_rem_q, div_dd_q[PW-1]};
	assign div_ge = (div_t >= {1'b0, div_d_q});
	assign div_rem_n = div_ge ? NNW'(div_t - {1'b0, div_d_q}) : NNW'(div_t);
	assign div_qn = {div_q_q[PW-2:0], div_ge};

	assign sq_t = {sq_rem_q[RMW-3:0], sq_v_q[VAR_W-1 -: 2]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};
	assign sq_ge = (sq_t >= sq_trial);
	assign sq_rem_n = sq_ge ? (sq_t - sq_trial) : sq_t;
	assign sq_root_n = {sq_root_q[ROOT_W-2:0], sq_ge};

	// sample ring, one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ring_rd_q <= ring_mem[slot_q];
		end
		if (state_q == ST_READ) begin
			ring_mem[slot_q] <= s_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mul_op_q <= OP_SQ_NEW;
			div_op_q <= DV_VAR;
			slot_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			s2_q <= '0;
			lowest_q <= MIN_RESET;
			highest_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						s_q <= rtt_sample;
						if (rtt_sample < lowest_q) lowest_q <= rtt_sample;
						if (rtt_sample > highest_q) highest_q <= rtt_sample;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					old_q <= ring_rd_q;
					was_full_q <= full;
					if (full) begin
						sum_q <= sum_q - SW'(ring_rd_q) + SW'(s_q);
					end else begin
						sum_q <= sum_q + SW'(s_q);
						fill_q <= fill_q + 1'b1;
					end
					slot_q <= (slot_q == SLW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					mul_a_q <= PW'(s_q);
					mul_b_q <= SW'(s_q);
					mul_p_q <= '0;
					mul_cnt_q <= MCW'(SW);
					mul_op_q <= OP_SQ_NEW;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_cnt_q == MCW'(1)) begin
						mul_p_q <= '0;
						mul_cnt_q <= MCW'(SW);
						unique case (mul_op_q)
							OP_SQ_NEW: begin
								s2_q <= s2_q + S2W'(mul_next);
								if (was_full_q) begin
									mul_a_q <= PW'(old_q);
									mul_b_q <= SW'(old_q);
									mul_op_q <= OP_SQ_OLD;
								end else begin
									mul_a_q <= PW'(s2_q + S2W'(mul_next));
									mul_b_q <= SW'(fill_q);
									mul_op_q <= OP_N_S2;
								end
							end
							OP_SQ_OLD: begin
								s2_q <= s2_q - S2W'(mul_next);
								mul_a_q <= PW'(s2_q - S2W'(mul_next));
								mul_b_q <= SW'(fill_q);
								mul_op_q <= OP_N_S2;
							end
							OP_N_S2: begin
								ns2_q <= mul_next;
								mul_a_q <= PW'(sum_q);
								mul_b_q <= sum_q;
								mul_op_q <= OP_S1_SQ;
							end
							OP_S1_SQ: begin
								num_q <= ns2_q - mul_next;
								mul_a_q <= PW'(fill_q);
								mul_b_q <= SW'(fill_q);
								mul_op_q <= OP_NN;
							end
							OP_NN: begin
								div_dd_q <= num_q;
								div_d_q <= NNW'(mul_next);
								div_rem_q <= '0;
								div_q_q <= '0;
								div_cnt_q <= DCW'(PW);
								div_op_q <= DV_VAR;
								state_q <= ST_DIV;
							end
							default: state_q <= ST_IDLE;
						endcase
					end else begin
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
						mul_p_q <= mul_next;
						mul_cnt_q <= mul_cnt_q - 1'b1;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == DCW'(1)) begin
						unique case (div_op_q)
							DV_VAR: begin
								sq_v_q <= VAR_W'(div_qn);
								// mean: sum left-aligned so only its bits are shifted in
								div_dd_q <= PW'(sum_q) << (PW - SW);
								div_d_q <= NNW'(fill_q);
								div_rem_q <= '0;
								div_q_q <= '0;
								div_cnt_q <= DCW'(SW);
								div_op_q <= DV_MEAN;
							end
							DV_MEAN: begin
								mean_q <= SAMPLE_W'(div_qn);
								sq_rem_q <= '0;
								sq_root_q <= '0;
								sq_cnt_q <= RCW'(ROOT_W);
								state_q <= ST_SQRT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end else begin
						div_dd_q <= div_dd_q << 1;
						div_rem_q <= div_rem_n;
						div_q_q <= div_qn;
						div_cnt_q <= div_cnt_q - 1'b1;
					end
				end
				ST_SQRT: begin
					sq_v_q <= sq_v_q << 2;
					sq_rem_q <= sq_rem_n;
					sq_root_q <= sq_root_n;
					sq_cnt_q <= sq_cnt_q - 1'b1;
					if (sq_cnt_q == RCW'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						mean_o_q <= mean_q;
						min_o_q <= lowest_q;
						max_o_q <= highest_q;
						jit_o_q <= sq_root_q;
						held_o_q <= fill_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign mean_rtt = mean_o_q;
	assign min_rtt = min_o_q;
	assign max_rtt = max_o_q;
	assign jitter_rtt = jit_o_q;
	assign samples_held = HELD_W'(held_o_q);
endmodule

/* rtl/core/rws_checker.sv */
`timescale 1ns / 1ps
`include "rtt_window_statistics_core_assert.svh"
module rws_checker
	import rws_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] mean_rtt,
	input logic [SAMPLE_W-1:0] min_rtt,
	input logic [SAMPLE_W-1:0] max_rtt
);
	// a stalled result transaction holds
	`RWS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(mean_rtt))
	// lifetime min never passes lifetime max once a sample is in
	`RWS_ASSERT_ALWAYS(a_min_le_max, clk, out_valid |-> min_rtt <= max_rtt)
	// window mean is bounded by the lifetime max
	`RWS_ASSERT(a_mean_le_max, clk, arst_n, out_valid |-> mean_rtt <= max_rtt)
endmodule

bind rtt_window_statistics_core rws_checker u_rws_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.mean_rtt(mean_rtt),
	.min_rtt(min_rtt),
	.max_rtt(max_rtt)
);
